/* rtl/mlspe_pkg.sv */
package mlspe_pkg;

   // fixed geometry of the block
   localparam int LANES        = 6;
   localparam int REGS_DEFAULT = 8;
   localparam int DATA_W       = 32;
   localparam int IDX_W        = 3;
   localparam int OPCODE_W     = 3;
   localparam int STEP_W       = 8;
   localparam int CNT_W        = 5;
   localparam int PERM_LEN     = 3;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [STEP_W-1:0] STEP_LIMIT_RESET = 8'd16;
   localparam logic [STEP_W-1:0] STEP_MAX         = 8'd255;

   // command codes
   localparam logic CMD_EXEC    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // instruction codes
   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_AND  = 3'd2,
      OP_SLT  = 3'd3,
      OP_CMOV = 3'd4
   } opcode_type;

   // what the back end has to do with one beat
   typedef enum logic [1:0] {
      KIND_EXEC    = 2'd0,
      KIND_STEP    = 2'd1,
      KIND_RESTART = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [OPCODE_W-1:0]   opcode;
      logic [IDX_W-1:0]      dest_reg;
      logic [IDX_W-1:0]      src_a;
      logic [IDX_W-1:0]      src_b;
      logic [IDX_W-1:0]      src_cond;
   } entry_type;

   typedef struct packed {
      logic                  done_res;
      logic                  sorted;
      logic [CNT_W-1:0]      correct_count;
      logic [STEP_W-1:0]     step_count;
   } result_type;

   // starting contents of x1..x3, one permutation per lane
   localparam logic [1:0] START_PERM [LANES][PERM_LEN] = '{
      '{2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd3, 2'd2},
      '{2'd2, 2'd1, 2'd3},
      '{2'd2, 2'd3, 2'd1},
      '{2'd3, 2'd1, 2'd2},
      '{2'd3, 2'd2, 2'd1}
   };

   // value of register r of a lane after restart
   function automatic logic [DATA_W-1:0] start_value(input int lane, input int r);
      logic [DATA_W-1:0] val;
      val = '0;
      if (r >= 1 && r <= PERM_LEN) begin
         val = DATA_W'(START_PERM[lane][r-1]);
      end
      return val;
   endfunction

endpackage

/* rtl/mlspe_if.sv */
interface mlspe_req_if;
   logic                            valid;
   logic                            ready;
   logic                            cmd;
   logic [mlspe_pkg::OPCODE_W-1:0]  opcode;
   logic [mlspe_pkg::IDX_W-1:0]     dest_reg;
   logic [mlspe_pkg::IDX_W-1:0]     src_a;
   logic [mlspe_pkg::IDX_W-1:0]     src_b;
   logic [mlspe_pkg::IDX_W-1:0]     src_cond;

   modport source (
      output valid, cmd, opcode, dest_reg, src_a, src_b, src_cond,
      input  ready
   );
   modport sink (
      input  valid, cmd, opcode, dest_reg, src_a, src_b, src_cond,
      output ready
   );
endinterface

interface mlspe_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            done_res;
   logic                            sorted;
   logic [mlspe_pkg::CNT_W-1:0]     correct_count;
   logic [mlspe_pkg::STEP_W-1:0]    step_count;

   modport source (
      output valid, done_res, sorted, correct_count, step_count,
      input  ready
   );
   modport sink (
      input  valid, done_res, sorted, correct_count, step_count,
      output ready
   );
endinterface

/* rtl/mlspe_front.sv */
module mlspe_front #(
   parameter int REGS = mlspe_pkg::REGS_DEFAULT
) (
   mlspe_req_if.sink                req_chan,
   input  logic                     q_full,
   output logic                     q_push,
   output mlspe_pkg::entry_type     q_push_entry
);
   import mlspe_pkg::*;

   logic writes_reg;

   // take a beat whenever the queue has room
   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   // an instruction writes only for a known opcode and a real destination
   always_comb begin
      writes_reg = (req_chan.dest_reg != '0) && (32'(req_chan.dest_reg) < REGS);
      case (req_chan.opcode)
         OP_ADD, OP_SUB, OP_AND, OP_SLT, OP_CMOV: ;
         default: writes_reg = 1'b0;
      endcase
   end

   // classify the beat for the back end
   always_comb begin
      q_push_entry.opcode   = req_chan.opcode;
      q_push_entry.dest_reg = req_chan.dest_reg;
      q_push_entry.src_a    = req_chan.src_a;
      q_push_entry.src_b    = req_chan.src_b;
      q_push_entry.src_cond = req_chan.src_cond;
      if (req_chan.cmd == CMD_RESTART) begin
         q_push_entry.kind = KIND_RESTART;
      end else if (writes_reg) begin
         q_push_entry.kind = KIND_EXEC;
      end else begin
         q_push_entry.kind = KIND_STEP;
      end
   end

endmodule

/* rtl/mlspe_queue.sv */
module mlspe_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mlspe_pkg::entry_type     push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     pop_valid,
   output mlspe_pkg::entry_type     pop_entry
);
   import mlspe_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   entry_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_QW'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/mlspe_back.sv */
module mlspe_back #(
   parameter int REGS = mlspe_pkg::REGS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  mlspe_pkg::entry_type              q_entry,
   output logic                              q_pop,
   input  logic [mlspe_pkg::STEP_W-1:0]      step_limit,
   mlspe_rsp_if.source                       rsp_chan
);
   import mlspe_pkg::*;

   logic [DATA_W-1:0]  regs_ff [LANES][REGS];
   logic [DATA_W-1:0]  regs_in [LANES][REGS];
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic               score_pend_ff, score_pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff;
   result_type         score;
   logic               capture;
   logic               issue;
   logic [DATA_W-1:0]  opa [LANES];
   logic [DATA_W-1:0]  opb [LANES];
   logic [DATA_W-1:0]  opc [LANES];
   logic [DATA_W-1:0]  alu [LANES];
   logic [LANES*PERM_LEN-1:0] hit_vec;

   // scoring of the item applied last, then issue of the next one
   assign capture = score_pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign issue   = q_valid && (!score_pend_ff || capture);
   assign q_pop   = issue;

   // operand select and alu, one per lane
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         opa[l] = '0;
         opb[l] = '0;
         opc[l] = '0;
         for (int r = 1; r < REGS; r++) begin
            if (32'(q_entry.src_a) == r) opa[l] = regs_ff[l][r];
            if (32'(q_entry.src_b) == r) opb[l] = regs_ff[l][r];
            if (32'(q_entry.src_cond) == r) opc[l] = regs_ff[l][r];
         end
         case (q_entry.opcode)
            OP_ADD:  alu[l] = opa[l] + opb[l];
            OP_SUB:  alu[l] = opa[l] - opb[l];
            OP_AND:  alu[l] = opa[l] & opb[l];
            OP_SLT:  alu[l] = ($signed(opa[l]) < $signed(opb[l])) ? DATA_W'(1) : '0;
            OP_CMOV: alu[l] = (opc[l] != '0) ? opa[l] : opb[l];
            default: alu[l] = '0;
         endcase
      end
   end

   // register file and step counter update
   always_comb begin
      regs_in  = regs_ff;
      steps_in = steps_ff;
      if (issue) begin
         case (q_entry.kind)
            KIND_RESTART: begin
               for (int l = 0; l < LANES; l++) begin
                  for (int r = 0; r < REGS; r++) begin
                     regs_in[l][r] = start_value(l, r);
                  end
               end
               steps_in = '0;
            end
            KIND_EXEC: begin
               for (int l = 0; l < LANES; l++) begin
                  for (int r = 1; r < REGS; r++) begin
                     if (32'(q_entry.dest_reg) == r) regs_in[l][r] = alu[l];
                  end
               end
               if (steps_ff != STEP_MAX) steps_in = steps_ff + 1'b1;
            end
            KIND_STEP: begin
               if (steps_ff != STEP_MAX) steps_in = steps_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LANES; l++) begin
            for (int r = 0; r < REGS; r++) begin
               regs_ff[l][r] <= start_value(l, r);
            end
         end
         steps_ff <= '0;
      end else begin
         regs_ff  <= regs_in;
         steps_ff <= steps_in;
      end
   end

   // progress score from the state left by the last item
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         for (int k = 1; k <= PERM_LEN; k++) begin
            hit_vec[l*PERM_LEN + k - 1] = (regs_ff[l][k] == DATA_W'(k));
         end
      end
      score.done_res      = (steps_ff >= step_limit);
      score.sorted        = &hit_vec;
      score.correct_count = CNT_W'($countones(hit_vec));
      score.step_count    = steps_ff;
   end

   // output register handshake
   always_comb begin
      score_pend_in = score_pend_ff;
      if (issue) begin
         score_pend_in = 1'b1;
      end else if (capture) begin
         score_pend_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         score_pend_ff <= score_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         rsp_data_ff <= score;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.done_res      = rsp_data_ff.done_res;
   assign rsp_chan.sorted        = rsp_data_ff.sorted;
   assign rsp_chan.correct_count = rsp_data_ff.correct_count;
   assign rsp_chan.step_count    = rsp_data_ff.step_count;

endmodule

/* rtl/multi_lane_sort_program_executor_core.sv */
// Six-lane register-file executor for sorting-program search.
// req_chan: one beat per instruction (cmd 0) or episode restart (cmd 1); the
//    instruction is applied to all six lanes of eight 32-bit registers at once.
// rsp_chan: one beat per request beat, in order, with done_res, sorted,
//    correct_count and step_count taken after that request's update.
// csr_wr_en/csr_wr_data: step limit at which done_res is raised (reset 16);
//    write it only while no request is in flight.
// Path: an accepted request is written into the queue, then executed into the
//    register file, then scored into the output register; a stall on
//    rsp_chan.ready can hold it back between these steps.
// Throughput: one beat per cycle in both directions while rsp_chan.ready
//    stays high; the six lane alus are combinational and the register file is written as the instruction issues.
// A two-entry queue between the classify front and the execute back lets
//    the front keep taking beats while a response waits on rsp_chan.ready;
//    when the response is stalled, the back stops and the queue fills, then
//    req_chan.ready drops.
// Reset: lanes reload the starting permutations, the step count clears, the
//    queue and response register empty, and the step limit returns to 16.
module multi_lane_sort_program_executor_core #(
   parameter int REGS = mlspe_pkg::REGS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   mlspe_req_if.sink                      req_chan,
   mlspe_rsp_if.source                    rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [mlspe_pkg::STEP_W-1:0]   csr_wr_data
);
   import mlspe_pkg::*;

   logic [STEP_W-1:0]  limit_ff, limit_in;
   logic               q_full;
   logic               q_push;
   entry_type          q_push_entry;
   logic               q_pop;
   logic               q_valid;
   entry_type          q_entry;

   // step limit register
   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= STEP_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // classify front
   mlspe_front #(.REGS(REGS)) u_front (
      .req_chan     (req_chan),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_push_entry (q_push_entry)
   );

   // decoupling queue
   mlspe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   // execute back end
   mlspe_back #(.REGS(REGS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .step_limit (limit_ff),
      .rsp_chan   (rsp_chan)
   );

   // checks
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.correct_count <= CNT_W'(LANES * PERM_LEN)))
      else $error("correct count out of range");

   a_sorted_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.sorted)
         |-> (rsp_chan.correct_count == CNT_W'(LANES * PERM_LEN)))
      else $error("sorted without every position correct");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import mlspe_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_GAP      = 4;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_DIRECTED = 26;

   // reserved opcodes, executed as no-ops that still count a step
   localparam logic [OPCODE_W-1:0] OP_RSV_FIRST = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_RSV_LAST  = 3'd7;

   // register names
   localparam logic [IDX_W-1:0] X0 = 3'd0;
   localparam logic [IDX_W-1:0] X1 = 3'd1;
   localparam logic [IDX_W-1:0] X2 = 3'd2;
   localparam logic [IDX_W-1:0] X3 = 3'd3;
   localparam logic [IDX_W-1:0] X4 = 3'd4;
   localparam logic [IDX_W-1:0] X5 = 3'd5;
   localparam logic [IDX_W-1:0] X6 = 3'd6;
   localparam logic [IDX_W-1:0] X7 = 3'd7;

   typedef struct packed {
      logic                cmd;
      logic [OPCODE_W-1:0] opcode;
      logic [IDX_W-1:0]    dest;
      logic [IDX_W-1:0]    src_a;
      logic [IDX_W-1:0]    src_b;
      logic [IDX_W-1:0]    src_cond;
   } instr_beat_type;

   typedef struct packed {
      instr_beat_type beat;
      logic           typed;
      result_type     score;
   } directed_row_type;

   // directed beats; rows with typed set carry a hand-written score
   localparam directed_row_type DIRECTED [NUM_DIRECTED] = '{
      '{'{CMD_RESTART, OP_ADD, X0, X0, X0, X0}, 1'b1, '{1'b0, 1'b0, 5'd6, 8'd0}},
      '{'{CMD_EXEC, OP_RSV_FIRST, X1, X2, X3, X4}, 1'b1, '{1'b0, 1'b0, 5'd6, 8'd1}},
      '{'{CMD_EXEC, OP_RSV_LAST, X7, X7, X7, X7}, 1'b1, '{1'b0, 1'b0, 5'd6, 8'd2}},
      '{'{CMD_EXEC, OP_ADD, X0, X1, X2, X0}, 1'b1, '{1'b0, 1'b0, 5'd6, 8'd3}},
      '{'{CMD_EXEC, OP_ADD, X7, X1, X2, X0}, 1'b0, '0},
      '{'{CMD_EXEC, OP_SUB, X6, X0, X7, X0}, 1'b0, '0},
      '{'{CMD_EXEC, OP_SLT, X5, X6, X7, X0}, 1'b0, '0},
      '{'{CMD_EXEC, OP_SLT, X5, X7, X6, X0}, 1'b0, '0},
      '{'{CMD_EXEC, OP_AND, X4, X7, X6, X0}, 1'b0, '0},
      '{'{CMD_EXEC, OP_CMOV, X4, X1, X2, X5}, 1'b0, '0},
      '{'{CMD_EXEC, OP_CMOV, X4, X1, X2, X7}, 1'b0, '0},
      '{'{CMD_EXEC, OP_CMOV, X1, X7, X7, X0}, 1'b0, '0},
      '{'{CMD_EXEC, OP_SUB, X2, X2, X2, X0}, 1'b0, '0},
      '{'{CMD_RESTART, OP_ADD, X0, X0, X0, X0}, 1'b1, '{1'b0, 1'b0, 5'd6, 8'd0}},
      // three compare-swaps sort every lane
      '{'{CMD_EXEC, OP_SLT, X4, X2, X1, X0}, 1'b0, '0},
      '{'{CMD_EXEC, OP_CMOV, X5, X2, X1, X4}, 1'b0, '0},
      '{'{CMD_EXEC, OP_CMOV, X2, X1, X2, X4}, 1'b0, '0},
      '{'{CMD_EXEC, OP_ADD, X1, X5, X0, X0}, 1'b0, '0},
      '{'{CMD_EXEC, OP_SLT, X4, X3, X2, X0}, 1'b0, '0},
      '{'{CMD_EXEC, OP_CMOV, X5, X3, X2, X4}, 1'b0, '0},
      '{'{CMD_EXEC, OP_CMOV, X3, X2, X3, X4}, 1'b0, '0},
      '{'{CMD_EXEC, OP_ADD, X2, X5, X0, X0}, 1'b0, '0},
      '{'{CMD_EXEC, OP_SLT, X4, X2, X1, X0}, 1'b0, '0},
      '{'{CMD_EXEC, OP_CMOV, X5, X2, X1, X4}, 1'b0, '0},
      '{'{CMD_EXEC, OP_CMOV, X2, X1, X2, X4}, 1'b0, '0},
      '{'{CMD_EXEC, OP_ADD, X1, X5, X0, X0}, 1'b1, '{1'b0, 1'b1, 5'd18, 8'd12}}
   };

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [STEP_W-1:0]   csr_wr_data;

   mlspe_req_if req_chan ();
   mlspe_rsp_if rsp_chan ();

   multi_lane_sort_program_executor_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the lane registers, step counter and step limit
   logic [DATA_W-1:0]  lane_file [LANES][REGS_DEFAULT];
   logic [STEP_W-1:0]  step_ctr;
   logic [STEP_W-1:0]  step_lim;

   result_type   expected_scores [$];
   int unsigned  mismatch_cnt = 0;
   int unsigned  beats_sent;
   int unsigned  scores_seen = 0;
   int unsigned  cycle_cnt = 0;
   bit           idle_on;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_cnt++;
      $display("%0t: %s", $time, what);
   endtask

   // every lane back to its starting permutation, scratch registers cleared
   function automatic void load_start_state();
      int l;
      int r;
      for (l = 0; l < LANES; l++) begin
         for (r = 0; r < REGS_DEFAULT; r++) begin
            lane_file[l][r] = '0;
         end
         for (r = 0; r < PERM_LEN; r++) begin
            lane_file[l][r+1] = DATA_W'(START_PERM[l][r]);
         end
      end
   endfunction

   // apply one beat to the shadow state and score the lanes afterwards
   function automatic result_type apply_and_score(input instr_beat_type b);
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] bv;
      logic [DATA_W-1:0] c;
      logic [DATA_W-1:0] r;
      result_type        s;
      int unsigned       hits;
      int                l;
      int                k;
      if (b.cmd == CMD_RESTART) begin
         load_start_state();
         step_ctr = '0;
      end else begin
         if (step_ctr != STEP_MAX) begin
            step_ctr = step_ctr + 1'b1;
         end
         if (b.dest != X0 && b.opcode <= OP_CMOV) begin
            for (l = 0; l < LANES; l++) begin
               a  = lane_file[l][b.src_a];
               bv = lane_file[l][b.src_b];
               c  = lane_file[l][b.src_cond];
               case (b.opcode)
                  OP_ADD: r = a + bv;
                  OP_SUB: r = a - bv;
                  OP_AND: r = a & bv;
                  OP_SLT: r = ($signed(a) < $signed(bv)) ? DATA_W'(1) : '0;
                  default: r = (c != '0) ? a : bv;
               endcase
               lane_file[l][b.dest] = r;
            end
         end
      end
      hits = 0;
      for (l = 0; l < LANES; l++) begin
         for (k = 1; k <= PERM_LEN; k++) begin
            if (lane_file[l][k] == DATA_W'(k)) begin
               hits++;
            end
         end
      end
      s.done_res      = (step_ctr >= step_lim);
      s.sorted        = (hits == LANES * PERM_LEN);
      s.correct_count = CNT_W'(hits);
      s.step_count    = step_ctr;
      return s;
   endfunction

   function automatic instr_beat_type rand_beat(input bit may_restart);
      instr_beat_type b;
      b.cmd      = (may_restart && $urandom_range(0, 15) == 0) ? CMD_RESTART : CMD_EXEC;
      b.opcode   = OPCODE_W'($urandom_range(0, 7));
      b.dest     = IDX_W'($urandom_range(0, 7));
      b.src_a    = IDX_W'($urandom_range(0, 7));
      b.src_b    = IDX_W'($urandom_range(0, 7));
      b.src_cond = IDX_W'($urandom_range(0, 7));
      return b;
   endfunction

   // drive one request beat, wait for it to be taken, queue its score
   task automatic send_beat(input instr_beat_type b, input logic typed,
                            input result_type typed_score);
      int unsigned gap;
      result_type  predicted;
      gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.cmd      <= b.cmd;
      req_chan.opcode   <= b.opcode;
      req_chan.dest_reg <= b.dest;
      req_chan.src_a    <= b.src_a;
      req_chan.src_b    <= b.src_b;
      req_chan.src_cond <= b.src_cond;
      do @(posedge clock); while (!req_chan.ready);
      predicted = apply_and_score(b);
      expected_scores.insert(expected_scores.size(), typed ? typed_score : predicted);
      beats_sent++;
   endtask

   // min into lo, max into hi, using flag and keep as scratch
   task automatic send_compare_swap(input logic [IDX_W-1:0] lo, hi, flag, keep,
                                    input bit may_restart);
      instr_beat_type prog [4];
      prog[0] = '{CMD_EXEC, OP_SLT, flag, hi, lo, X0};
      prog[1] = '{CMD_EXEC, OP_CMOV, keep, hi, lo, flag};
      prog[2] = '{CMD_EXEC, OP_CMOV, hi, lo, hi, flag};
      prog[3] = '{CMD_EXEC, OP_ADD, lo, keep, X0, X0};
      foreach (prog[i]) begin
         // now and then a stray beat breaks the program
         send_beat(($urandom_range(0, 11) == 0) ? rand_beat(may_restart) : prog[i],
                   1'b0, '0);
      end
   endtask

   // request side quiet and every score back, then let the pipe settle
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_step_limit(input logic [STEP_W-1:0] limit);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      step_lim = limit;
   endtask

   // sort programs, overflow runs and noise, mixed
   task automatic run_random(input int unsigned count, input bit may_restart);
      int unsigned       first;
      logic [IDX_W-1:0]  flag;
      logic [IDX_W-1:0]  keep;
      logic [IDX_W-1:0]  acc;
      first = beats_sent;
      while (beats_sent - first < count) begin
         idle_on = ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               // sorting network with random scratch registers
               flag = IDX_W'($urandom_range(4, 7));
               keep = (flag == X7) ? X4 : flag + 1'b1;
               if (may_restart) begin
                  send_beat('{CMD_RESTART, OP_ADD, X0, X0, X0, X0}, 1'b0, '0);
               end
               case ($urandom_range(0, 2))
                  0: begin
                     send_compare_swap(X1, X2, flag, keep, may_restart);
                     send_compare_swap(X2, X3, flag, keep, may_restart);
                     send_compare_swap(X1, X2, flag, keep, may_restart);
                  end
                  1: begin
                     send_compare_swap(X2, X3, flag, keep, may_restart);
                     send_compare_swap(X1, X2, flag, keep, may_restart);
                     send_compare_swap(X2, X3, flag, keep, may_restart);
                  end
                  default: begin
                     send_compare_swap(X1, X3, flag, keep, may_restart);
                     send_compare_swap(X1, X2, flag, keep, may_restart);
                     send_compare_swap(X2, X3, flag, keep, may_restart);
                  end
               endcase
            end
            5: begin
               // repeated doubling walks through the sign bit and wraps to zero
               acc = IDX_W'($urandom_range(4, 7));
               send_beat('{CMD_EXEC, OP_ADD, acc, X3, X0, X0}, 1'b0, '0);
               if ($urandom_range(0, 1) == 1) begin
                  send_beat('{CMD_EXEC, OP_SUB, acc, X0, acc, X0}, 1'b0, '0);
               end
               repeat ($urandom_range(28, 34)) begin
                  send_beat('{CMD_EXEC, OP_ADD, acc, acc, acc, X0}, 1'b0, '0);
               end
            end
            default: begin
               repeat ($urandom_range(4, 12)) send_beat(rand_beat(may_restart), 1'b0, '0);
            end
         endcase
      end
   endtask

   // response side: random stall before each beat
   initial begin
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // compare each response beat with the oldest expected score
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.done_res      = rsp_chan.done_res;
         got.sorted        = rsp_chan.sorted;
         got.correct_count = rsp_chan.correct_count;
         got.step_count    = rsp_chan.step_count;
         if (expected_scores.size() == 0) begin
            report_mismatch($sformatf("response beat %0d with no request pending",
                                      scores_seen));
         end else begin
            want = expected_scores.pop_front();
            if (got.done_res !== want.done_res) begin
               report_mismatch($sformatf("beat %0d done_res got %b want %b",
                                         scores_seen, got.done_res, want.done_res));
            end
            if (got.sorted !== want.sorted) begin
               report_mismatch($sformatf("beat %0d sorted got %b want %b",
                                         scores_seen, got.sorted, want.sorted));
            end
            if (got.correct_count !== want.correct_count) begin
               report_mismatch($sformatf("beat %0d correct_count got %0d want %0d",
                                         scores_seen, got.correct_count,
                                         want.correct_count));
            end
            if (got.step_count !== want.step_count) begin
               report_mismatch($sformatf("beat %0d step_count got %0d want %0d",
                                         scores_seen, got.step_count, want.step_count));
            end
         end
         scores_seen++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("Mismatches found");
         $finish;
      end
   end

   // reset, then directed beats and random phases at several step limits
   initial begin
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.cmd      <= CMD_EXEC;
      req_chan.opcode   <= '0;
      req_chan.dest_reg <= '0;
      req_chan.src_a    <= '0;
      req_chan.src_b    <= '0;
      req_chan.src_cond <= '0;
      beats_sent        = 0;
      idle_on           = 1'b1;
      load_start_state();
      step_ctr = '0;
      step_lim = STEP_LIMIT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset step limit
      foreach (DIRECTED[i]) begin
         send_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].score);
      end
      wait_idle();

      write_step_limit(8'd1);
      run_random(250, 1'b1);
      wait_idle();

      // no restarts here so the step count saturates
      write_step_limit(STEP_MAX);
      run_random(350, 1'b0);
      wait_idle();

      // limit of zero reports done on every beat
      write_step_limit(8'd0);
      run_random(200, 1'b1);
      wait_idle();

      write_step_limit(STEP_W'($urandom_range(2, 254)));
      run_random(250, 1'b1);
      wait_idle();

      write_step_limit(STEP_LIMIT_RESET);
      run_random(250, 1'b1);
      wait_idle();

      if (mismatch_cnt == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
